>>> hw/rtl/rc4sc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher unit: shared package
// Widths, operation codes and the key store request bundle.
// ----------------------------------------------------------------------------
package rc4sc_pkg;

	localparam int unsigned ByteW     = 8;
	localparam int unsigned KeyDepth  = 256;
	localparam int unsigned PermDepth = 256;
	localparam int unsigned KeyIdxW   = $clog2(KeyDepth);
	localparam int unsigned KeyLenW   = 9;
	localparam int unsigned ApbAddrW  = 3;
	localparam int unsigned ApbDataW  = 32;

	localparam logic [KeyLenW-1:0] KeyLenReset = KeyLenW'(16);
	localparam logic               RegKeyLength = 1'b0;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_SCHEDULE = 2'd1,
		OP_CRYPT    = 2'd2
	} op_t;

	typedef struct packed {
		logic               we;
		logic [KeyIdxW-1:0] waddr;
		logic [ByteW-1:0]   wdata;
		logic [KeyIdxW-1:0] raddr;
	} key_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/rc4sc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher unit: channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface rc4sc_in_if;
	logic              valid;
	logic              ready;
	rc4sc_pkg::op_t    operation;
	logic [7:0]        key_index;
	logic [7:0]        key_byte;
	logic [7:0]        data_in;
	logic              last_in;

	modport source (output valid, operation, key_index, key_byte, data_in, last_in,
		input ready);
	modport sink (input valid, operation, key_index, key_byte, data_in, last_in,
		output ready);
endinterface

interface rc4sc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       schedule_done;
	logic       last_out;

	modport source (output valid, data_out, schedule_done, last_out, input ready);
	modport sink (input valid, data_out, schedule_done, last_out, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rc4sc_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher unit: configuration registers
// APB register file holding the key length and deriving its wrap point.
// ----------------------------------------------------------------------------
module rc4sc_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [rc4sc_pkg::ApbAddrW-1:0]     paddr,
	input  wire logic [rc4sc_pkg::ApbDataW-1:0]     pwdata,
	output logic      [rc4sc_pkg::ApbDataW-1:0]     prdata,
	output logic                                    pready,
	output logic      [rc4sc_pkg::KeyIdxW-1:0]      key_last
);
	import rc4sc_pkg::*;

	logic [KeyLenW-1:0] key_length_q;
	logic               sel_key_length;

	assign sel_key_length = (paddr[ApbAddrW-1] == RegKeyLength);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= KeyLenReset;
		end else if (psel && penable && pwrite && sel_key_length) begin
			key_length_q <= pwdata[KeyLenW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_key_length) begin
			prdata = ApbDataW'(key_length_q);
		end
	end

	// Last key position used before the key index wraps to zero.
	always_comb begin
		if (key_length_q <= KeyLenW'(1)) begin
			key_last = '0;
		end else if (key_length_q >= KeyLenW'(KeyDepth)) begin
			key_last = KeyIdxW'(KeyDepth - 1);
		end else begin
			key_last = KeyIdxW'(key_length_q - KeyLenW'(1));
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/rc4sc_key_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher unit: key store
// One write port and one registered read port over the key bytes.
// ----------------------------------------------------------------------------
module rc4sc_key_mem (
	input  wire logic                         clk,
	input  wire rc4sc_pkg::key_req_t          req,
	output logic [rc4sc_pkg::ByteW-1:0]       rdata
);
	import rc4sc_pkg::*;

	logic [ByteW-1:0] key_q [KeyDepth];

	always_ff @(posedge clk) begin
		if (req.we) begin
			key_q[req.waddr] <= req.wdata;
		end
		rdata <= key_q[req.raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/rc4sc_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher unit: permutation engine
// Sequencer around the permutation memory for key schedule and keystream.
// ----------------------------------------------------------------------------
module rc4sc_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	rc4sc_in_if.sink                           in_word,
	rc4sc_out_if.source                        out_word,
	input  wire logic [rc4sc_pkg::KeyIdxW-1:0] key_last,
	output rc4sc_pkg::key_req_t                key_req,
	input  wire logic [rc4sc_pkg::ByteW-1:0]   key_rdata
);
	import rc4sc_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_INIT = 10'b00_0000_0010,
		ST_SA   = 10'b00_0000_0100,
		ST_SB   = 10'b00_0000_1000,
		ST_SC   = 10'b00_0001_0000,
		ST_SD   = 10'b00_0010_0000,
		ST_CB   = 10'b00_0100_0000,
		ST_CC   = 10'b00_1000_0000,
		ST_CD   = 10'b01_0000_0000,
		ST_OUT  = 10'b10_0000_0000
	} state_t;

	state_t           state_q;
	logic [ByteW-1:0] perm_q [PermDepth];
	logic [ByteW-1:0] rda_q, rdb_q;
	logic [ByteW-1:0] addr_a, addr_b, wr_addr, wr_data;
	logic             wr_en;
	logic [ByteW-1:0] i_q, j_q, si_q, sj_q, t_q;
	logic [KeyIdxW-1:0] k_q;
	logic [ByteW-1:0] data_q;
	logic             last_q, done_q;
	logic             accept, slot_free;
	logic [ByteW-1:0] ks;
	logic             ovalid_q, odone_q, olast_q;
	logic [ByteW-1:0] odata_q;

	assign in_word.ready = (state_q == ST_IDLE);
	assign accept        = in_word.valid && in_word.ready;
	assign slot_free     = !ovalid_q || out_word.ready;

	always_comb begin
		addr_a  = i_q;
		addr_b  = j_q;
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = rdb_q;
		key_req.we    = 1'b0;
		key_req.waddr = in_word.key_index;
		key_req.wdata = in_word.key_byte;
		key_req.raddr = k_q;
		case (state_q)
			ST_IDLE: begin
				addr_a = i_q + 8'd1;
				key_req.we = accept && (in_word.operation == OP_LOAD);
			end
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_data = i_q;
			end
			ST_SB: addr_b = j_q + rda_q + key_rdata;
			ST_SC: wr_en = 1'b1;
			ST_SD: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = si_q;
			end
			ST_CB: addr_b = j_q + rda_q;
			ST_CC: begin
				wr_en  = 1'b1;
				addr_a = si_q + rdb_q;
			end
			ST_CD: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = si_q;
			end
			default: ;
		endcase
	end

	// The keystream read overlaps the swap writes, so the swapped entries are forwarded.
	always_comb begin
		if (t_q == i_q) begin
			ks = sj_q;
		end else if (t_q == j_q) begin
			ks = si_q;
		end else begin
			ks = rda_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			perm_q[wr_addr] <= wr_data;
		end
		rda_q <= perm_q[addr_a];
		rdb_q <= perm_q[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_word.operation)
							OP_SCHEDULE: begin
								i_q     <= '0;
								state_q <= ST_INIT;
							end
							OP_CRYPT: begin
								i_q     <= i_q + 8'd1;
								state_q <= ST_CB;
							end
							default: ;
						endcase
					end
				end
				ST_INIT: begin
					i_q <= i_q + 8'd1;
					if (i_q == 8'hFF) begin
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_SA;
					end
				end
				ST_SA: state_q <= ST_SB;
				ST_SB: begin
					j_q     <= addr_b;
					state_q <= ST_SC;
				end
				ST_SC: state_q <= ST_SD;
				ST_SD: begin
					i_q <= i_q + 8'd1;
					k_q <= (k_q == key_last) ? '0 : k_q + KeyIdxW'(1);
					if (i_q == 8'hFF) begin
						j_q     <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SA;
					end
				end
				ST_CB: begin
					j_q     <= addr_b;
					state_q <= ST_CC;
				end
				ST_CC: state_q <= ST_CD;
				ST_CD: state_q <= ST_OUT;
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					data_q <= in_word.data_in;
					last_q <= in_word.last_in;
					done_q <= 1'b0;
				end
			end
			ST_SB, ST_CB: si_q <= rda_q;
			ST_SD: begin
				data_q <= '0;
				last_q <= 1'b0;
				done_q <= 1'b1;
			end
			ST_CC: begin
				sj_q <= rdb_q;
				t_q  <= addr_a;
			end
			ST_CD: data_q <= data_q ^ ks;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_OUT && slot_free) begin
			ovalid_q <= 1'b1;
		end else if (out_word.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && slot_free) begin
			odata_q <= data_q;
			odone_q <= done_q;
			olast_q <= last_q;
		end
	end

	assign out_word.valid         = ovalid_q;
	assign out_word.data_out      = odata_q;
	assign out_word.schedule_done = odone_q;
	assign out_word.last_out      = olast_q;

endmodule
`default_nettype wire

>>> hw/rtl/rc4_stream_cipher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher unit
// RC4 engine with key loading, key schedule and byte-wise encryption.
// ----------------------------------------------------------------------------
// A key-load word gives no result. A crypt word runs through the states CB, CC
// and CD to the output stage, which waits while a previous result is held; the
// input is ready again as its result enters the output register, so a crypt
// word is not taken while another is in progress. It makes three dependent
// accesses to the permutation memory (read S[i], read S[j], keystream read
// overlapped with the swap writes). A schedule word writes the identity
// permutation through the single write port, then makes 256 swap steps through
// the states SA, SB, SC and SD, bounded by the memory's registered reads and
// one write per cycle, before the output stage. One word is processed at a time;
// a finished result waits in the output register while the next word is
// accepted. Write the key length only while the unit is idle.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rc4sc_pkg::ApbAddrW-1:0] paddr,
	input  wire logic [rc4sc_pkg::ApbDataW-1:0] pwdata,
	output logic      [rc4sc_pkg::ApbDataW-1:0] prdata,
	output logic                                pready,
	rc4sc_in_if.sink                            in_word,
	rc4sc_out_if.source                         out_word
);
	import rc4sc_pkg::*;

	logic [KeyIdxW-1:0] key_last;
	key_req_t           key_req;
	logic [ByteW-1:0]   key_rdata;

	rc4sc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.key_last (key_last)
	);

	rc4sc_key_mem u_key_mem (
		.clk   (clk),
		.req   (key_req),
		.rdata (key_rdata)
	);

	rc4sc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.out_word  (out_word),
		.key_last  (key_last),
		.key_req   (key_req),
		.key_rdata (key_rdata)
	);

endmodule
`default_nettype wire

>>> hw/rtl/rc4sc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher unit: port checker
// Assertions on the ports of the top level, attached by bind.
// ----------------------------------------------------------------------------
module rc4sc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire rc4sc_pkg::op_t in_operation,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire logic [7:0]     out_data,
	input wire logic           out_done,
	input wire logic           out_last
);
	import rc4sc_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_done |-> out_data == 8'd0 && !out_last)
		else $error("schedule done word carries data");

	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_operation == OP_SCHEDULE || in_operation == OP_CRYPT)
		|=> !in_ready)
		else $error("input taken while a word is in progress");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_operation == OP_LOAD && !out_valid |=> !out_valid)
		else $error("key load produced a result");

endmodule

bind rc4_stream_cipher_unit rc4sc_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_word.valid),
	.in_ready     (in_word.ready),
	.in_operation (in_word.operation),
	.out_valid    (out_word.valid),
	.out_ready    (out_word.ready),
	.out_data     (out_word.data_out),
	.out_done     (out_word.schedule_done),
	.out_last     (out_word.last_out)
);
`default_nettype wire

>>> tb/tb_rc4_stream_cipher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher unit: self-checking testbench
// Drives key loads, key schedules and crypt words through the input channel
// and programs the key length over APB. A built-in cipher model predicts every
// result word, and each word leaving the output channel is checked against
// it. The run covers short directed cases, an index wrap run, random phases
// under several idling mixes and key lengths, and one long output hold.
// ----------------------------------------------------------------------------
module tb_rc4_stream_cipher_unit;
	import rc4sc_pkg::*;

	localparam logic [1:0]          OpUnused       = 2'd3;
	localparam logic [ApbAddrW-1:0] KeyLengthAddr  = ApbAddrW'(4 * RegKeyLength);
	localparam int unsigned         LongHoldCycles = 300;
	localparam int unsigned         PhaseWords     = 90;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] key_index;
		logic [7:0] key_byte;
		logic [7:0] data_in;
		logic       last_in;
	} cipher_word_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       schedule_done;
		logic       last_out;
	} cipher_result_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	rc4sc_in_if  in_word_if ();
	rc4sc_out_if out_word_if ();

	rc4_stream_cipher_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_word  (in_word_if),
		.out_word (out_word_if)
	);

	logic [7:0]         sbox [PermDepth];
	logic [7:0]         key_mem [KeyDepth];
	bit                 key_written [KeyDepth];
	logic [7:0]         idx_i;
	logic [7:0]         idx_j;
	logic [KeyLenW-1:0] key_len_reg;
	bit                 sbox_valid;
	cipher_result_t     expected_results [$];

	int unsigned words_sent;
	int unsigned schedules_sent;
	int unsigned crypts_sent;
	int unsigned results_seen;
	int unsigned settings_used;
	int unsigned error_count;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	logic        holding;
	event        long_hold;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned used_key_len();
		if (key_len_reg == '0) begin
			return 1;
		end
		if (key_len_reg > KeyLenW'(KeyDepth)) begin
			return KeyDepth;
		end
		return 32'(key_len_reg);
	endfunction

	function automatic void predict_word(input cipher_word_t w);
		int unsigned    len;
		logic [7:0]     acc;
		logic [7:0]     tmp;
		logic [7:0]     pick;
		cipher_result_t res;
		len = used_key_len();
		case (w.op)
			OP_LOAD: begin
				key_mem[w.key_index] = w.key_byte;
				key_written[w.key_index] = 1'b1;
				words_sent++;
			end
			OP_SCHEDULE: begin
				for (int k = 0; k < PermDepth; k++) begin
					sbox[k] = 8'(k);
				end
				acc = '0;
				for (int unsigned k = 0; k < PermDepth; k++) begin
					acc = acc + sbox[k] + key_mem[k % len];
					tmp = sbox[k];
					sbox[k] = sbox[acc];
					sbox[acc] = tmp;
				end
				idx_i = '0;
				idx_j = '0;
				sbox_valid = 1'b1;
				res = '{data_out: 8'h00, schedule_done: 1'b1, last_out: 1'b0};
				expected_results.push_back(res);
				schedules_sent++;
				words_sent++;
			end
			OP_CRYPT: begin
				idx_i = idx_i + 8'd1;
				idx_j = idx_j + sbox[idx_i];
				tmp = sbox[idx_i];
				sbox[idx_i] = sbox[idx_j];
				sbox[idx_j] = tmp;
				pick = sbox[idx_i] + sbox[idx_j];
				res = '{data_out: w.data_in ^ sbox[pick], schedule_done: 1'b0,
					last_out: w.last_in};
				expected_results.push_back(res);
				crypts_sent++;
				words_sent++;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic cipher_word_t random_word(input logic [1:0] op);
		cipher_word_t w;
		w.op = op;
		w.key_index = 8'($urandom);
		w.key_byte = 8'($urandom);
		w.data_in = 8'($urandom);
		w.last_in = 1'($urandom);
		return w;
	endfunction

	task automatic send_word(input cipher_word_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			in_word_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_word_if.valid <= 1'b1;
		in_word_if.operation <= op_t'(w.op);
		in_word_if.key_index <= w.key_index;
		in_word_if.key_byte <= w.key_byte;
		in_word_if.data_in <= w.data_in;
		in_word_if.last_in <= w.last_in;
		@(posedge clk);
		while (!in_word_if.ready) @(posedge clk);
		predict_word(w);
	endtask

	task automatic send_load(input logic [7:0] index);
		cipher_word_t w;
		w = random_word(OP_LOAD);
		w.key_index = index;
		send_word(w);
	endtask

	task automatic send_crypt_burst(input int unsigned count, input bit mark_last);
		cipher_word_t w;
		for (int unsigned k = 1; k <= count; k++) begin
			w = random_word(OP_CRYPT);
			w.last_in = mark_last && (k == count);
			send_word(w);
		end
	endtask

	task automatic wait_idle(input int unsigned settle);
		in_word_if.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_key_length(input logic [KeyLenW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= KeyLengthAddr;
		pwdata <= ApbDataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		key_len_reg = value;
		settings_used++;
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct = 0;
		write_key_length(KeyLenW'(1));
		send_word('{OP_LOAD, 8'd0, 8'hFF, 8'h00, 1'b0});
		send_word('{OP_LOAD, 8'd255, 8'h00, 8'hFF, 1'b1});
		send_word('{OpUnused, 8'hFF, 8'hFF, 8'hFF, 1'b1});
		send_word('{OP_SCHEDULE, 8'h00, 8'h00, 8'h00, 1'b0});
		send_word('{OP_CRYPT, 8'h00, 8'h00, 8'h00, 1'b0});
		send_word('{OP_CRYPT, 8'hFF, 8'hFF, 8'hFF, 1'b1});
		send_word('{OP_CRYPT, 8'h00, 8'h00, 8'hA5, 1'b0});
		send_word('{OpUnused, 8'h00, 8'h00, 8'h00, 1'b0});
		send_word('{OP_CRYPT, 8'h00, 8'h00, 8'h5A, 1'b1});
		wait_idle(8);
		write_key_length(KeyLenW'(0));
		send_word('{OP_LOAD, 8'd0, 8'h00, 8'h00, 1'b0});
		send_word('{OP_SCHEDULE, 8'hFF, 8'hFF, 8'hFF, 1'b1});
		send_word('{OP_CRYPT, 8'h00, 8'h00, 8'hFF, 1'b0});
		send_word('{OP_CRYPT, 8'h00, 8'h00, 8'h00, 1'b1});
	endtask

	task automatic test_index_wrap();
		send_idle_pct = 0;
		stall_pct = 0;
		send_word(random_word(OP_SCHEDULE));
		send_crypt_burst(300, 1'b1);
	endtask

	task automatic test_random_phase(input int unsigned send_pct, input int unsigned stall,
		input logic [KeyLenW-1:0] len);
		int unsigned start;
		int unsigned eff;
		int unsigned pick;
		wait_idle(8);
		write_key_length(len);
		send_idle_pct = send_pct;
		stall_pct = stall;
		start = words_sent;
		eff = used_key_len();
		while (words_sent - start < PhaseWords) begin
			pick = $urandom_range(99);
			if (!sbox_valid || pick < 12) begin
				for (int unsigned k = 0; k < eff; k++) begin
					if (!key_written[k]) begin
						send_load(8'(k));
					end
				end
				repeat ($urandom_range(4)) send_load(8'($urandom_range(eff - 1)));
				send_word(random_word(OP_SCHEDULE));
			end else if (pick < 88) begin
				send_crypt_burst($urandom_range(1, 40), pick < 82);
			end else if (pick < 95) begin
				send_load(8'($urandom));
			end else begin
				send_word(random_word(OpUnused));
			end
		end
	endtask

	task automatic test_output_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		-> long_hold;
		send_crypt_burst(40, 1'b1);
	endtask

	initial begin
		out_word_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_word_if.ready <= !holding && ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		holding <= 1'b0;
		forever begin
			@(long_hold);
			@(posedge clk);
			holding <= 1'b1;
			repeat (LongHoldCycles) @(posedge clk);
			holding <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cipher_result_t want;
		if (arst_n && out_word_if.valid && out_word_if.ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result word: data_out %02h schedule_done %0b last_out %0b",
					$time, out_word_if.data_out, out_word_if.schedule_done,
					out_word_if.last_out);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (out_word_if.data_out !== want.data_out) begin
					$display("%0t: data_out mismatch: expected %02h, actual %02h",
						$time, want.data_out, out_word_if.data_out);
					error_count++;
				end
				if (out_word_if.schedule_done !== want.schedule_done) begin
					$display("%0t: schedule_done mismatch: expected %0b, actual %0b",
						$time, want.schedule_done, out_word_if.schedule_done);
					error_count++;
				end
				if (out_word_if.last_out !== want.last_out) begin
					$display("%0t: last_out mismatch: expected %0b, actual %0b",
						$time, want.last_out, out_word_if.last_out);
					error_count++;
				end
			end
		end
	end

	initial begin
		#6_000_000;
		$display("%0t: timeout with %0d result words outstanding",
			$time, expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_word_if.valid <= 1'b0;
		in_word_if.operation <= OP_LOAD;
		in_word_if.key_index <= '0;
		in_word_if.key_byte <= '0;
		in_word_if.data_in <= '0;
		in_word_if.last_in <= 1'b0;
		key_len_reg = KeyLenReset;
		idx_i = '0;
		idx_j = '0;
		sbox_valid = 1'b0;
		for (int k = 0; k < KeyDepth; k++) begin
			key_written[k] = 1'b0;
		end
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_index_wrap();
		test_random_phase(0, 0, KeyLenW'(511));
		test_random_phase(0, 0, KeyLenW'(16));
		test_random_phase(87, 0, KeyLenW'(1));
		test_random_phase(87, 0, KeyLenW'(256));
		test_random_phase(0, 87, KeyLenW'(2));
		test_random_phase(0, 87, KeyLenW'(255));
		test_random_phase(22, 22, KeyLenW'(7));
		test_random_phase(22, 22, KeyLenW'(100));
		test_output_backpressure();
		wait_idle(20);

		$display("Accepted %0d words: %0d key schedules, %0d crypt bytes, the rest key loads.",
			words_sent, schedules_sent, crypts_sent);
		$display("Checked %0d result words over %0d key length settings and four idling mixes.",
			results_seen, settings_used);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
